>>> rtl/olrk_pkg.sv
package olrk_pkg;

  localparam int LIST_DEPTH = 64;
  localparam int IDX_W      = $clog2(LIST_DEPTH);
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
  localparam int DATA_W     = 32;

  typedef logic [DATA_W-1:0] data_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  // request kinds
  localparam logic [1:0] KIND_APPEND = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_DUMP   = 2'd2;

  // result status codes
  localparam logic [2:0] ST_APPENDED   = 3'd0;
  localparam logic [2:0] ST_FULL       = 3'd1;
  localparam logic [2:0] ST_REMOVED    = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND  = 3'd3;
  localparam logic [2:0] ST_DUMP_ENTRY = 3'd4;
  localparam logic [2:0] ST_DUMP_EMPTY = 3'd5;

  typedef struct packed {
    logic  we;
    idx_t  waddr;
    data_t wdata;
    logic  re;
    idx_t  raddr;
  } ram_req_t;

endpackage

>>> rtl/olrk_ifs.sv
interface olrk_req_if;
  import olrk_pkg::*;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic signed [31:0] ident_value;

  modport source (output valid, kind, ident_value, input ready);
  modport sink   (input valid, kind, ident_value, output ready);
endinterface

interface olrk_rsp_if;
  import olrk_pkg::*;
  logic               valid;
  logic               ready;
  logic signed [31:0] entry_value;
  logic [2:0]         status;
  logic               last_of_run;

  modport source (output valid, entry_value, status, last_of_run, input ready);
  modport sink   (input valid, entry_value, status, last_of_run, output ready);
endinterface

>>> rtl/olrk_ram.sv
module olrk_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // read data holds until the next read
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/olrk_seq.sv
module olrk_seq (
  input  logic               clk,
  input  logic               rst_n,
  olrk_req_if.sink           in_req,
  olrk_rsp_if.source         out_rsp,
  output olrk_pkg::ram_req_t ram_req,
  input  olrk_pkg::data_t    ram_rdata
);
  import olrk_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RESP,
    S_SCAN,
    S_DUMP
  } state_t;

  state_t     state_r, state_nxt;
  cnt_t       count_r, count_nxt;
  cnt_t       k_r, k_nxt;
  idx_t       pk_r, pk_nxt;
  logic       pv_r, pv_nxt;
  logic       found_r, found_nxt;
  data_t      val_r, val_nxt;
  data_t      res_val_r, res_val_nxt;
  logic [2:0] res_st_r, res_st_nxt;

  logic       out_valid_r, out_valid_nxt;
  data_t      out_val_r, out_val_nxt;
  logic [2:0] out_st_r, out_st_nxt;
  logic       out_last_r, out_last_nxt;

  logic       slot_free;
  cnt_t       k_inc;

  assign slot_free = !out_valid_r || out_rsp.ready;
  assign k_inc     = k_r + CNT_W'(1);
  assign in_req.ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    k_nxt         = k_r;
    pk_nxt        = pk_r;
    pv_nxt        = pv_r;
    found_nxt     = found_r;
    val_nxt       = val_r;
    res_val_nxt   = res_val_r;
    res_st_nxt    = res_st_r;
    out_valid_nxt = out_valid_r && !out_rsp.ready;
    out_val_nxt   = out_val_r;
    out_st_nxt    = out_st_r;
    out_last_nxt  = out_last_r;
    ram_req       = '0;

    case (state_r)
      S_IDLE: begin
        if (in_req.valid) begin
          val_nxt     = data_t'(in_req.ident_value);
          res_val_nxt = data_t'(in_req.ident_value);
          case (in_req.kind)
            KIND_APPEND: begin
              if (count_r == CNT_W'(LIST_DEPTH)) begin
                res_st_nxt = ST_FULL;
              end else begin
                ram_req.we    = 1'b1;
                ram_req.waddr = count_r[IDX_W-1:0];
                ram_req.wdata = data_t'(in_req.ident_value);
                count_nxt     = count_r + CNT_W'(1);
                res_st_nxt    = ST_APPENDED;
              end
              state_nxt = S_RESP;
            end
            KIND_REMOVE: begin
              k_nxt     = '0;
              pv_nxt    = 1'b0;
              found_nxt = 1'b0;
              state_nxt = S_SCAN;
            end
            KIND_DUMP: begin
              if (count_r == '0) begin
                res_val_nxt = '0;
                res_st_nxt  = ST_DUMP_EMPTY;
                state_nxt   = S_RESP;
              end else begin
                ram_req.re    = 1'b1;
                ram_req.raddr = '0;
                k_nxt         = '0;
                state_nxt     = S_DUMP;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      S_RESP: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_val_nxt   = res_val_r;
          out_st_nxt    = res_st_r;
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      // One read per cycle; the entry read last cycle is compared or,
      // once the match is behind us, moved down one slot.
      S_SCAN: begin
        if (pv_r) begin
          if (found_r) begin
            ram_req.we    = 1'b1;
            ram_req.waddr = pk_r - IDX_W'(1);
            ram_req.wdata = ram_rdata;
          end else if (ram_rdata == val_r) begin
            found_nxt = 1'b1;
          end
        end
        if (k_r < count_r) begin
          ram_req.re    = 1'b1;
          ram_req.raddr = k_r[IDX_W-1:0];
          pk_nxt        = k_r[IDX_W-1:0];
          pv_nxt        = 1'b1;
          k_nxt         = k_inc;
        end else begin
          pv_nxt = 1'b0;
          if (!pv_r) begin
            res_val_nxt = val_r;
            if (found_r) begin
              res_st_nxt = ST_REMOVED;
              count_nxt  = count_r - CNT_W'(1);
            end else begin
              res_st_nxt = ST_NOT_FOUND;
            end
            state_nxt = S_RESP;
          end
        end
      end

      S_DUMP: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_val_nxt   = ram_rdata;
          out_st_nxt    = ST_DUMP_ENTRY;
          out_last_nxt  = (k_inc == count_r);
          if (k_inc == count_r) begin
            state_nxt = S_IDLE;
          end else begin
            ram_req.re    = 1'b1;
            ram_req.raddr = k_inc[IDX_W-1:0];
            k_nxt         = k_inc;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      pv_r        <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pv_r        <= pv_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
    k_r        <= k_nxt;
    pk_r       <= pk_nxt;
    val_r      <= val_nxt;
    res_val_r  <= res_val_nxt;
    res_st_r   <= res_st_nxt;
    out_val_r  <= out_val_nxt;
    out_st_r   <= out_st_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_rsp.valid       = out_valid_r;
  assign out_rsp.entry_value = out_val_r;
  assign out_rsp.status      = out_st_r;
  assign out_rsp.last_of_run = out_last_r;

endmodule

>>> rtl/ordered_list_remove_by_key_core.sv
// Append: the result is registered through S_RESP; the next request is taken back in S_IDLE.
// Remove: the scan reads one entry per cycle through the single RAM read port, then the
//   result goes out through S_RESP; the next request is taken back in S_IDLE.
// Dump: entries go out one per cycle while the result slot is free; the next request is
//   taken once the last entry is issued. Result backpressure stalls all of these.
// Reset (sync, active low) clears the entry count, sequencer and output valid; RAM not swept.
module ordered_list_remove_by_key_core (
  input  logic       clk,
  input  logic       rst_n,
  olrk_req_if.sink   in_req,
  olrk_rsp_if.source out_rsp
);
  import olrk_pkg::*;

  // request/response sequencer <-> entry store
  ram_req_t ram_req;
  data_t    ram_rdata;

  // Sequencer: owns the entry count, the remove scan/compaction pass,
  // the dump walk and the registered result slot toward out_rsp.
  olrk_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .out_rsp   (out_rsp),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata)
  );

  // Entry store: entries kept in arrival order at addresses 0..count-1.
  // During a remove, reads run two addresses ahead of the compaction write,
  // so the read and write never hit the same entry in one cycle.
  olrk_ram #(
    .DEPTH (LIST_DEPTH),
    .WIDTH (DATA_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

endmodule

>>> tb/tb_ordered_list_remove_by_key_core.sv
module tb_ordered_list_remove_by_key_core;
  import olrk_pkg::*;

  // kind code the block ignores: no result, no change to the list
  localparam logic [1:0] KIND_NONE = 2'd3;
  // longest stretch without any accepted request or result before giving up
  localparam int STALL_LIMIT = 5000;
  // cycles allowed after the last result; long enough to cover a full-depth scan
  localparam int DRAIN_CYCLES = LIST_DEPTH + 16;
  localparam int POOL_SIZE = 12;

  typedef struct {
    logic [1:0] kind;
    data_t      value;
  } list_req_t;

  typedef struct {
    data_t      entry_value;
    logic [2:0] status;
    logic       last_of_run;
  } list_rsp_t;

  logic clk;
  logic rst_n;

  olrk_req_if in_req ();
  olrk_rsp_if out_rsp ();

  ordered_list_remove_by_key_core dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_rsp (out_rsp)
  );

  always #5 clk = ~clk;

  // requests waiting to be offered, filled by the stimulus block
  list_req_t req_backlog[$];
  // results the list will owe us, oldest first
  list_rsp_t due_results[$];

  // shadow copy of the list contents
  data_t list_mem [LIST_DEPTH];
  cnt_t  list_len;

  // identifiers reused often so that removes hit and duplicates occur
  data_t key_pool [POOL_SIZE];

  int unsigned send_idle_pct;
  int unsigned take_stall_pct;
  int          mismatch_count;
  int          quiet_cycles;

  // Works out the results of one accepted request and updates the shadow list.
  function automatic void list_apply(logic [1:0] kind, data_t value);
    list_rsp_t rsp;
    int        hit;
    hit = -1;
    case (kind)
      KIND_APPEND: begin
        if (list_len >= LIST_DEPTH) begin
          rsp = '{value, ST_FULL, 1'b1};
        end else begin
          list_mem[list_len] = value;
          list_len = list_len + 1'b1;
          rsp = '{value, ST_APPENDED, 1'b1};
        end
        due_results.push_back(rsp);
      end
      KIND_REMOVE: begin
        // oldest match wins; the tail closes up behind it
        for (int i = 0; i < list_len; i++) begin
          if (hit < 0 && list_mem[i] == value) hit = i;
        end
        if (hit >= 0) begin
          for (int i = hit; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
          list_len = list_len - 1'b1;
          rsp = '{value, ST_REMOVED, 1'b1};
        end else begin
          rsp = '{value, ST_NOT_FOUND, 1'b1};
        end
        due_results.push_back(rsp);
      end
      KIND_DUMP: begin
        if (list_len == 0) begin
          rsp = '{'0, ST_DUMP_EMPTY, 1'b1};
          due_results.push_back(rsp);
        end else begin
          for (int i = 0; i < list_len; i++) begin
            rsp = '{list_mem[i], ST_DUMP_ENTRY, (i + 1 == list_len)};
            due_results.push_back(rsp);
          end
        end
      end
      default: ;
    endcase
  endfunction

  // Request driver; also feeds the shadow list on every accepted request.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_req.valid <= 1'b0;
    end else begin
      if (in_req.valid && in_req.ready) begin
        list_apply(in_req.kind, data_t'(in_req.ident_value));
      end
      // only move on once the current request is gone (or none is up)
      if (!in_req.valid || in_req.ready) begin
        if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          list_req_t nxt;
          nxt = req_backlog.pop_front();
          in_req.valid       <= 1'b1;
          in_req.kind        <= nxt.kind;
          in_req.ident_value <= nxt.value;
        end else begin
          in_req.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with randomized backpressure.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_rsp.ready <= 1'b0;
    end else begin
      if (out_rsp.valid && out_rsp.ready) begin
        if (due_results.size() == 0) begin
          $error("result with nothing due: entry_value=%h status=%0d last_of_run=%0b",
                 out_rsp.entry_value, out_rsp.status, out_rsp.last_of_run);
          mismatch_count++;
        end else begin
          list_rsp_t exp_rsp;
          exp_rsp = due_results.pop_front();
          if (data_t'(out_rsp.entry_value) !== exp_rsp.entry_value) begin
            $error("entry_value: expected %h, got %h",
                   exp_rsp.entry_value, out_rsp.entry_value);
            mismatch_count++;
          end
          if (out_rsp.status !== exp_rsp.status) begin
            $error("status: expected %0d, got %0d", exp_rsp.status, out_rsp.status);
            mismatch_count++;
          end
          if (out_rsp.last_of_run !== exp_rsp.last_of_run) begin
            $error("last_of_run: expected %0b, got %0b",
                   exp_rsp.last_of_run, out_rsp.last_of_run);
            mismatch_count++;
          end
        end
      end
      out_rsp.ready <= ($urandom_range(99) >= take_stall_pct);
    end
  end

  // Watchdog: any accepted request or result resets the count.
  always @(posedge clk) begin
    if (!rst_n || (in_req.valid && in_req.ready) || (out_rsp.valid && out_rsp.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("ordered_list_remove_by_key_core regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_req(logic [1:0] kind, data_t value);
    req_backlog.push_back('{kind, value});
  endtask

  // Mostly pool keys so removes find something; the rest full-range random.
  function automatic data_t pick_key();
    if ($urandom_range(99) < 70) return key_pool[$urandom_range(POOL_SIZE - 1)];
    return $urandom();
  endfunction

  // One idling phase: random mix of requests, optionally led by a fill to full.
  task automatic run_phase(int unsigned send_pct, int unsigned stall_pct,
                           int n_reqs, bit fill_first);
    int unsigned pick;
    send_idle_pct  = send_pct;
    take_stall_pct = stall_pct;
    if (fill_first) begin
      // enough appends to hit full from any fill level, then a full-depth dump
      for (int i = 0; i < LIST_DEPTH + 2; i++) queue_req(KIND_APPEND, pick_key());
      queue_req(KIND_DUMP, $urandom());
      // remove while full, then refill the freed slot
      queue_req(KIND_REMOVE, pick_key());
      queue_req(KIND_APPEND, pick_key());
    end
    for (int i = 0; i < n_reqs; i++) begin
      pick = $urandom_range(99);
      if (pick < 42)      queue_req(KIND_APPEND, pick_key());
      else if (pick < 80) queue_req(KIND_REMOVE, pick_key());
      else if (pick < 95) queue_req(KIND_DUMP, $urandom());
      else                queue_req(KIND_NONE, $urandom());
    end
    while (req_backlog.size() != 0) @(posedge clk);
  endtask

  initial begin
    clk            = 1'b0;
    rst_n          = 1'b0;
    in_req.valid       = 1'b0;
    in_req.kind        = KIND_APPEND;
    in_req.ident_value = '0;
    out_rsp.ready      = 1'b0;
    send_idle_pct  = 0;
    take_stall_pct = 0;
    mismatch_count = 0;
    list_len       = '0;

    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7fff_ffff;
    key_pool[2] = 32'h0000_0000;
    key_pool[3] = 32'hffff_ffff;
    key_pool[4] = $urandom();
    for (int k = 5; k < POOL_SIZE; k++) begin
      // near misses: differ from a neighbor in a single bit
      if (k % 2) key_pool[k] = key_pool[k-1] ^ (32'h1 << $urandom_range(31));
      else       key_pool[k] = $urandom();
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty list, extreme values, duplicates, front/middle/tail removes.
    queue_req(KIND_DUMP,   32'h1234_5678);   // empty dump
    queue_req(KIND_REMOVE, 32'h0000_0000);   // remove from empty list
    queue_req(KIND_APPEND, 32'h8000_0000);
    queue_req(KIND_APPEND, 32'h7fff_ffff);
    queue_req(KIND_APPEND, 32'h0000_0000);
    queue_req(KIND_APPEND, 32'hffff_ffff);
    queue_req(KIND_APPEND, 32'h7fff_ffff);   // duplicate at the tail
    queue_req(KIND_NONE,   32'h7fff_ffff);   // ignored kind
    queue_req(KIND_DUMP,   32'hffff_ffff);
    queue_req(KIND_REMOVE, 32'h7fff_fffe);   // off by one bit, not found
    queue_req(KIND_REMOVE, 32'hffff_7fff);   // off by one bit, not found
    queue_req(KIND_REMOVE, 32'h7fff_ffff);   // first of two duplicates goes
    queue_req(KIND_DUMP,   32'h0000_0000);
    queue_req(KIND_REMOVE, 32'h8000_0000);   // front entry
    queue_req(KIND_REMOVE, 32'h7fff_ffff);   // tail entry
    queue_req(KIND_APPEND, 32'h0000_0001);
    queue_req(KIND_REMOVE, 32'hffff_ffff);   // middle entry
    queue_req(KIND_DUMP,   32'h0000_0000);
    queue_req(KIND_REMOVE, 32'h0000_0000);
    queue_req(KIND_REMOVE, 32'h0000_0001);   // list empty again
    queue_req(KIND_DUMP,   32'h0000_0000);
    queue_req(KIND_NONE,   32'h0000_0000);

    // Random: no idling, sender idling, receiver stalling, both.
    run_phase(0,  0,  8, 1'b0);
    run_phase(47, 0,  8, 1'b0);
    run_phase(0,  47, 8, 1'b0);
    run_phase(29, 29, 8, 1'b1);

    while (req_backlog.size() != 0 || in_req.valid || due_results.size() != 0)
      @(posedge clk);
    // catch any stray result that trails the last expected one
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && due_results.size() == 0) begin
      $display("ordered_list_remove_by_key_core regression: pass");
    end else begin
      $display("ordered_list_remove_by_key_core regression: fail");
    end
    $finish;
  end

endmodule
